/* rtl/lfu_cache_lru_tiebreak_macros.svh */
// assertion macros, expect clk and rst_n in scope
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define LFU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define LFU_ASSERT(label, cond)
`define LFU_ASSERT_IMP(label, ante, cons)
`endif

`endif

/* rtl/lfu_pkg.sv */
package lfu_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W     = IDX_W;
    localparam int OCC_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CAP_W      = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } lfu_req_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
    } lfu_rsp_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [RANK_W-1:0]     hit_rank;
        logic [VAL_W-1:0]      hit_value;
        logic                  vic_valid;
        logic [IDX_W-1:0]      vic_idx;
        logic [COUNT_BITS-1:0] vic_count;
        logic [RANK_W-1:0]     vic_rank;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
    } lfu_chain_t;

    typedef struct packed {
        logic              touch;
        logic [IDX_W-1:0]  touch_idx;
        logic [RANK_W-1:0] touch_rank;
        logic              wr_value;
        logic              evict;
        logic [IDX_W-1:0]  ev_idx;
        logic [RANK_W-1:0] ev_rank;
        logic              insert;
        logic [IDX_W-1:0]  ins_idx;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } lfu_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

endpackage

/* rtl/lfu_cell.sv */
module lfu_cell
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic [KEY_W-1:0] lookup_key,
    input  lfu_op_t          op,
    input  lfu_chain_t       chain_in,
    output lfu_chain_t       chain_out,
    output logic             valid
);

    logic                  valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VAL_W-1:0]      value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    lfu_chain_t            chain_reg, chain_next;
    logic                  own_better;

    assign valid     = valid_reg;
    assign chain_out = chain_reg;

    // pass the running search result along the row
    always_comb
    begin
        chain_next = chain_in;
        if (valid_reg && key_reg == lookup_key)
        begin
            chain_next.hit       = 1'b1;
            chain_next.hit_idx   = idx;
            chain_next.hit_rank  = rank_reg;
            chain_next.hit_value = value_reg;
        end
        own_better = !chain_in.vic_valid || count_reg < chain_in.vic_count ||
                     (count_reg == chain_in.vic_count && rank_reg > chain_in.vic_rank);
        if (valid_reg && own_better)
        begin
            chain_next.vic_valid = 1'b1;
            chain_next.vic_idx   = idx;
            chain_next.vic_count = count_reg;
            chain_next.vic_rank  = rank_reg;
        end
        if (!valid_reg && !chain_in.free_found)
        begin
            chain_next.free_found = 1'b1;
            chain_next.free_idx   = idx;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (valid_reg)
        begin
            if (op.touch && rank_reg < op.touch_rank)
                rank_next = rank_reg + 1'b1;
            if (op.insert)
            begin
                if (op.evict && rank_reg > op.ev_rank)
                    rank_next = rank_reg;
                else
                    rank_next = rank_reg + 1'b1;
            end
        end
        if (op.touch && idx == op.touch_idx)
        begin
            rank_next = '0;
            if (count_reg != '1)
                count_next = count_reg + 1'b1;
            if (op.wr_value)
                value_next = op.value;
        end
        if (op.evict && idx == op.ev_idx)
            valid_next = 1'b0;
        if (op.insert && idx == op.ins_idx)
        begin
            valid_next = 1'b1;
            key_next   = op.key;
            value_next = op.value;
            count_next = COUNT_BITS'(1);
            rank_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            chain_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

endmodule

/* rtl/lfu_cache_lru_tiebreak.sv */
// channel | direction | payload    | transaction when
// in      | input     | lfu_req_t  | in_valid && in_ready
// out     | output    | lfu_rsp_t  | out_valid && out_ready
// cfg     | input     | 5-bit cap  | cfg_valid && cfg_ready
// one item at a time goes through accept, a pass down the 16-cell row, update
// the pass length is set by the registered hop between neighboring cells
// reset empties the store and sets capacity to 16
// a waiting result holds the update cycle; the next item is taken once the result is stored
`include "lfu_cache_lru_tiebreak_macros.svh"
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lfu_req_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lfu_rsp_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    lfu_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    lfu_req_t          req_reg;
    logic [OCC_W-1:0]  cap_reg, cap_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              out_valid_reg, out_valid_next;
    lfu_rsp_t          rsp_reg, rsp_next;
    lfu_chain_t        chain [ENTRIES+1];
    logic [ENTRIES-1:0] cell_valid;
    lfu_op_t           op;
    lfu_chain_t        cl;
    logic              apply, need_ev;

    assign chain[0] = '0;
    assign cl       = chain[ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lfu_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .idx        (IDX_W'(gi)),
                .lookup_key (req_reg.key),
                .op         (op),
                .chain_in   (chain[gi]),
                .chain_out  (chain[gi+1]),
                .valid      (cell_valid[gi])
            );
        end
    endgenerate

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign apply   = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
    assign need_ev = (occ_reg >= cap_reg);

    always_comb
    begin
        op            = '0;
        op.key        = req_reg.key;
        op.value      = req_reg.value;
        op.touch      = apply && cl.hit;
        op.touch_idx  = cl.hit_idx;
        op.touch_rank = cl.hit_rank;
        op.wr_value   = (req_reg.command == CMD_PUT);
        op.insert     = apply && req_reg.command == CMD_PUT && !cl.hit && cap_reg != '0;
        op.evict      = op.insert && need_ev;
        op.ev_idx     = cl.vic_idx;
        op.ev_rank    = cl.vic_rank;
        if (!need_ev)
            op.ins_idx = cl.free_idx;
        else if (cl.free_found && cl.free_idx < cl.vic_idx)
            op.ins_idx = cl.free_idx;
        else
            op.ins_idx = cl.vic_idx;
    end

    always_comb
    begin
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (op.insert && !need_ev)
            occ_next = occ_reg + 1'b1;
        if (cfg_valid && occ_reg == '0)
        begin
            if (OCC_W'(cfg_data) > OCC_W'(ENTRIES))
                cap_next = OCC_W'(ENTRIES);
            else
                cap_next = OCC_W'(cfg_data);
        end
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (apply)
        begin
            out_valid_next      = 1'b1;
            rsp_next.found      = cl.hit;
            rsp_next.read_value = (req_reg.command == CMD_GET && cl.hit) ? cl.hit_value : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= OCC_W'(ENTRIES < 16 ? ENTRIES : 16);
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (in_valid && in_ready)
            req_reg <= in_data;
    end

    `LFU_ASSERT(a_occ_cap, occ_reg <= cap_reg)
    `LFU_ASSERT(a_occ_count, $countones(cell_valid) == 32'(occ_reg))
    `LFU_ASSERT_IMP(a_victim, op.evict, cl.vic_valid)
    `LFU_ASSERT_IMP(a_free_slot, op.insert && !op.evict, cl.free_found)

endmodule

/* tb/tb_lfu_cache_lru_tiebreak.sv */
module tb_lfu_cache_lru_tiebreak;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 680;

    class lfu_scoreboard;
        bit                    slot_used[ENTRIES];
        logic [KEY_W-1:0]      slot_key[ENTRIES];
        logic [VAL_W-1:0]      slot_val[ENTRIES];
        logic [COUNT_BITS-1:0] slot_count[ENTRIES];
        int                    slot_rank[ENTRIES];
        int                    fill;
        int                    capacity;
        lfu_rsp_t              awaited[$];
        int                    errors;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            fill = 0;
            capacity = ENTRIES;
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            if (fill != 0)
                return;
            capacity = (v > ENTRIES) ? ENTRIES : int'(v);
        endfunction

        function void promote(int s);
            foreach (slot_used[i])
                if (slot_used[i] && slot_rank[i] < slot_rank[s])
                    slot_rank[i]++;
            slot_rank[s] = 0;
            if (slot_count[s] != '1)
                slot_count[s]++;
        endfunction

        function void note_request(lfu_req_t r);
            lfu_rsp_t rsp;
            int       hit;
            int       victim;
            int       freed;
            hit = -1;
            rsp = '0;
            foreach (slot_used[i])
                if (hit < 0 && slot_used[i] && slot_key[i] == r.key)
                    hit = i;
            if (r.command == CMD_GET) begin
                if (hit >= 0) begin
                    rsp.read_value = slot_val[hit];
                    promote(hit);
                end
            end else if (capacity != 0) begin
                if (hit >= 0) begin
                    slot_val[hit] = r.value;
                    promote(hit);
                end else begin
                    while (fill >= capacity && fill > 0) begin
                        victim = -1;
                        foreach (slot_used[i])
                            if (slot_used[i] && (victim < 0 ||
                                slot_count[i] < slot_count[victim] ||
                                (slot_count[i] == slot_count[victim] &&
                                 slot_rank[i] > slot_rank[victim])))
                                victim = i;
                        slot_used[victim] = 1'b0;
                        foreach (slot_used[i])
                            if (slot_used[i] && slot_rank[i] > slot_rank[victim])
                                slot_rank[i]--;
                        fill--;
                    end
                    freed = -1;
                    foreach (slot_used[i]) begin
                        if (slot_used[i])
                            slot_rank[i]++;
                        else if (freed < 0)
                            freed = i;
                    end
                    slot_used[freed] = 1'b1;
                    slot_key[freed] = r.key;
                    slot_val[freed] = r.value;
                    slot_count[freed] = 1;
                    slot_rank[freed] = 0;
                    fill++;
                end
            end
            rsp.found = (hit >= 0);
            awaited.push_back(rsp);
        endfunction

        function void check_response(lfu_rsp_t got);
            lfu_rsp_t exp_rsp;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected response found=%0b read_value=%h",
                         $realtime, got.found, got.read_value);
                errors++;
                return;
            end
            exp_rsp = awaited.pop_front();
            if (got.found !== exp_rsp.found) begin
                $display("%0t: found expected %0b actual %0b",
                         $realtime, exp_rsp.found, got.found);
                errors++;
            end
            if (got.read_value !== exp_rsp.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $realtime, exp_rsp.read_value, got.read_value);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    lfu_req_t         in_data;
    logic             out_valid;
    logic             out_ready;
    lfu_rsp_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    lfu_scoreboard    sb = new();
    bit               idling = 1'b1;
    int               hold_left = 0;
    int               stall_left = 0;
    int               cycles = 0;
    logic [KEY_W-1:0] key_pool[20];

    lfu_cache_lru_tiebreak i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_response(out_data);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        lfu_req_t r;
        r.command = cmd;
        r.key = k;
        r.value = v;
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(v);
    endtask

    initial
    begin
        logic [KEY_W-1:0] k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capacity zero: puts ignored
        write_capacity(5'd0);
        send_request(CMD_PUT, '1, 32'h1234_5678);
        send_request(CMD_GET, '1, '0);
        send_request(CMD_PUT, '0, '1);
        send_request(CMD_GET, '0, '1);

        // above-range capacity saturates; later writes are dropped as the store is not empty
        write_capacity(5'd31);
        send_request(CMD_PUT, 32'h0000_0010, 32'h0000_0001);
        send_request(CMD_GET, 32'h0000_0010, '0);
        write_capacity(5'd2);
        write_capacity(5'd16);
        write_capacity(5'($urandom_range(1, 16)));

        send_request(CMD_PUT, '0, '1);
        send_request(CMD_GET, '0, '0);
        send_request(CMD_PUT, '0, '0);
        send_request(CMD_GET, '0, '1);
        send_request(CMD_GET, '1, '0);
        send_request(CMD_PUT, '1, 32'hA5A5_5A5A);
        send_request(CMD_GET, '1, '0);
        for (int i = 0; i < 18; i++)
            send_request(CMD_PUT, key_pool[i % 20 + 2 > 19 ? 2 : i % 20 + 2], $urandom);
        send_request(CMD_GET, '0, '0);

        // store not empty: write is dropped
        write_capacity(5'd0);
        send_request(CMD_PUT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_request(CMD_GET, 32'hDEAD_BEEF, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200)
                hold_left = 300;
            if (n == 400)
                drain();
            if (n == RANDOM_ITEMS - 80)
                idling = 1'b0;
            k = ($urandom_range(0, 9) < 9) ? key_pool[$urandom_range(0, 19)] : $urandom;
            send_request(logic'($urandom_range(0, 1)), k, $urandom);
        end

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
